>>> sv/sphere_frustum_cull_top_defines.svh
// Assertion macros used by the sphere culling top level.
`ifndef SPHERE_FRUSTUM_CULL_TOP_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_TOP_DEFINES_SVH

// Checked on every rising edge outside reset.
`define SFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/sfc_pkg.sv
package sfc_pkg;

  // Default configuration.
  localparam int unsigned NumPlanesDef  = 6;
  localparam int unsigned CoordWidthDef = 32;

  // Fixed layout of the request and result words.
  localparam int unsigned WordsPerPlane = 4;
  localparam int unsigned FieldWidth    = 32;
  localparam int unsigned PlaneIdxWidth = 3;
  localparam int unsigned FracBits      = 16;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TEST = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    COMP_NX = 2'd0,
    COMP_NY = 2'd1,
    COMP_NZ = 2'd2,
    COMP_D  = 2'd3
  } comp_e;

  typedef struct packed {
    func_e                            func;
    logic [PlaneIdxWidth-1:0]         plane_index;
    comp_e                            component;
    logic signed [FieldWidth-1:0]     coeff;
    logic signed [FieldWidth-1:0]     center_x;
    logic signed [FieldWidth-1:0]     center_y;
    logic signed [FieldWidth-1:0]     center_z;
    logic [FieldWidth-2:0]            sphere_radius;
    logic                             last_in;
  } req_t;

  typedef struct packed {
    logic visible;
    logic last_out;
  } res_t;

  // Plane table write port.
  typedef struct packed {
    logic                         en;
    logic [PlaneIdxWidth-1:0]     plane;
    comp_e                        comp;
    logic signed [FieldWidth-1:0] data;
  } wr_t;

endpackage

>>> sv/sfc_plane_table.sv
module sfc_plane_table #(
  parameter int unsigned NumPlanes  = sfc_pkg::NumPlanesDef,
  parameter int unsigned CoordWidth = sfc_pkg::CoordWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sfc_pkg::wr_t                 wr_i,
  output logic signed [CoordWidth-1:0] words_o [NumPlanes][sfc_pkg::WordsPerPlane]
);

  logic signed [CoordWidth-1:0] words_q [NumPlanes][sfc_pkg::WordsPerPlane];

  // A write to a plane beyond the table matches no entry and is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPlanes; p++) begin
        for (int c = 0; c < sfc_pkg::WordsPerPlane; c++) begin
          words_q[p][c] <= '0;
        end
      end
    end else begin
      for (int p = 0; p < NumPlanes; p++) begin
        for (int c = 0; c < sfc_pkg::WordsPerPlane; c++) begin
          if (wr_i.en && wr_i.plane == sfc_pkg::PlaneIdxWidth'(p) &&
              wr_i.comp == sfc_pkg::comp_e'(c)) begin
            words_q[p][c] <= wr_i.data[CoordWidth-1:0];
          end
        end
      end
    end
  end

  assign words_o = words_q;

endmodule

>>> sv/sfc_plane_lane.sv
module sfc_plane_lane #(
  parameter int unsigned CoordWidth = sfc_pkg::CoordWidthDef
) (
  input  logic                         clk_i,
  input  logic signed [CoordWidth-1:0] nx_i,
  input  logic signed [CoordWidth-1:0] ny_i,
  input  logic signed [CoordWidth-1:0] nz_i,
  input  logic signed [CoordWidth-1:0] d_i,
  input  logic signed [CoordWidth-1:0] cx_i,
  input  logic signed [CoordWidth-1:0] cy_i,
  input  logic signed [CoordWidth-1:0] cz_i,
  input  logic [CoordWidth-2:0]        radius_i,
  output logic                         cull_o
);

  localparam int unsigned ProdWidth = 2 * CoordWidth;
  localparam int unsigned BiasWidth = CoordWidth + 1 + sfc_pkg::FracBits;
  localparam int unsigned SumWidth  = ProdWidth + 3;

  logic signed [ProdWidth-1:0]  px_d, py_d, pz_d;
  logic signed [ProdWidth-1:0]  px_q, py_q, pz_q;
  logic signed [CoordWidth:0]   dr_sum;
  logic signed [BiasWidth-1:0]  bias_d, bias_q;
  logic signed [SumWidth-1:0]   dist_sum;

  // First step: the three products and the offset plus radius, both at Q32.32.
  assign px_d   = ProdWidth'(nx_i) * ProdWidth'(cx_i);
  assign py_d   = ProdWidth'(ny_i) * ProdWidth'(cy_i);
  assign pz_d   = ProdWidth'(nz_i) * ProdWidth'(cz_i);
  assign dr_sum = $signed({d_i[CoordWidth-1], d_i}) + $signed({2'b00, radius_i});
  assign bias_d = $signed({dr_sum, {sfc_pkg::FracBits{1'b0}}});

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    pz_q   <= pz_d;
    bias_q <= bias_d;
  end

  // Second step: exact sum; the sphere lies wholly outside when it is negative.
  assign dist_sum = SumWidth'(px_q) + SumWidth'(py_q) + SumWidth'(pz_q) + SumWidth'(bias_q);
  assign cull_o   = dist_sum[SumWidth-1];

endmodule

>>> sv/sphere_frustum_cull_top.sv
// Channel   Ports                      Direction  Handshake
// request   start_i, busy_o, req_i     in         taken when start_i high and busy_o low
// result    done_o, res_o              out        one cycle wide, cannot be held off
//
// One request is taken in every cycle; busy_o never rises.
// A test request is taken into the input register, passes the product register in each
// plane lane and shows its result from the result register.
// A load request writes the plane table in the cycle after it is taken and gives no result.
// Reset is asynchronous and active low; it clears the pipeline valids and the plane
// table, after which every sphere is reported visible.
// The receiver cannot stall, so the pipeline never waits.

`include "sphere_frustum_cull_top_defines.svh"

module sphere_frustum_cull_top #(
  parameter int unsigned NumPlanes  = sfc_pkg::NumPlanesDef,
  parameter int unsigned CoordWidth = sfc_pkg::CoordWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  sfc_pkg::req_t req_i,
  output logic          done_o,
  output sfc_pkg::res_t res_o
);

  // Input register. A load writes the table from here, so a test taken in the
  // cycle after a load already sees the new word, and a test taken before it
  // has read the table into its products by the time the write lands.
  logic          s0_valid_q;
  sfc_pkg::req_t s0_req_q;

  // Product stage: only test requests travel on.
  logic s1_valid_q;
  logic s1_last_q;

  // Result register.
  logic          done_q;
  sfc_pkg::res_t res_q;

  sfc_pkg::wr_t                 tbl_wr;
  logic signed [CoordWidth-1:0] plane_words [NumPlanes][sfc_pkg::WordsPerPlane];
  logic [NumPlanes-1:0]         plane_cull;
  logic                         s0_test;
  logic                         accept;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign s0_test = s0_valid_q && (s0_req_q.func == sfc_pkg::FUNC_TEST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s0_valid_q <= accept;
      s1_valid_q <= s0_test;
      done_q     <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_req_q <= req_i;
    end
    s1_last_q      <= s0_req_q.last_in;
    res_q.visible  <= ~|plane_cull;
    res_q.last_out <= s1_last_q;
  end

  assign tbl_wr.en    = s0_valid_q && (s0_req_q.func == sfc_pkg::FUNC_LOAD);
  assign tbl_wr.plane = s0_req_q.plane_index;
  assign tbl_wr.comp  = s0_req_q.component;
  assign tbl_wr.data  = s0_req_q.coeff;

  sfc_plane_table #(
    .NumPlanes (NumPlanes),
    .CoordWidth(CoordWidth)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (tbl_wr),
    .words_o(plane_words)
  );

  // One lane per plane; all planes are tested side by side.
  for (genvar p = 0; p < NumPlanes; p++) begin : g_lane
    sfc_plane_lane #(
      .CoordWidth(CoordWidth)
    ) u_lane (
      .clk_i   (clk_i),
      .nx_i    (plane_words[p][sfc_pkg::COMP_NX]),
      .ny_i    (plane_words[p][sfc_pkg::COMP_NY]),
      .nz_i    (plane_words[p][sfc_pkg::COMP_NZ]),
      .d_i     (plane_words[p][sfc_pkg::COMP_D]),
      .cx_i    ($signed(s0_req_q.center_x[CoordWidth-1:0])),
      .cy_i    ($signed(s0_req_q.center_y[CoordWidth-1:0])),
      .cz_i    ($signed(s0_req_q.center_z[CoordWidth-1:0])),
      .radius_i(s0_req_q.sphere_radius[CoordWidth-2:0]),
      .cull_o  (plane_cull[p])
    );
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // A test in the input register reaches the product stage next cycle.
  `SFC_ASSERT(a_test_advances, s0_test |=> s1_valid_q, "test request lost in pipeline")
  // A load never travels towards a result.
  `SFC_ASSERT(a_load_no_result, (s0_valid_q && !s0_test) |=> !s1_valid_q, "load made a result")
  // Every result comes from a product stage entry in the previous cycle, and vice versa.
  `SFC_ASSERT(a_result_source, done_o == $past(s1_valid_q), "result without a test")
  // Nothing is reported while reset is held.
  `SFC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !done_o, "result during reset")

endmodule

>>> tb/sphere_frustum_cull_top_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the sphere against frustum culling block.
//
// Requests are queued up front by the stimulus process and then fed to the block by a
// clocked driver. Each request that the block takes is also passed to a local predictor.
// That predictor keeps its own copy of the plane table. Loads update the copy. Tests
// produce the expected result, which is pushed onto a queue. A clocked monitor pops that
// queue for every result strobe and compares each field. A watchdog ends the run if
// nothing moves for too long.
module sphere_frustum_cull_top_tb;

  localparam int unsigned TargetItems = 650;
  localparam int unsigned QuietLimit  = 1000;
  // Drain time after the last result, to catch any stray strobe from the block's pipeline.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumPhases   = 5;
  // Percentage of cycles in which the sender holds back, one entry per phase of the run.
  localparam int unsigned GapPct [NumPhases] = '{0, 59, 8, 0, 59};

  localparam logic signed [31:0] One     = 32'sh0001_0000;
  localparam logic signed [31:0] MaxWord = 32'sh7fff_ffff;
  localparam logic signed [31:0] MinWord = 32'sh8000_0000;
  localparam logic [30:0]        MaxRad  = 31'h7fff_ffff;

  typedef struct {
    sfc_pkg::req_t req;
    int unsigned   gap_pct;
  } pending_req_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  logic          busy_o;
  sfc_pkg::req_t req_i;
  logic          done_o;
  sfc_pkg::res_t res_o;

  pending_req_t      pending_reqs[$];
  sfc_pkg::res_t     expected_results[$];
  // Local copy of the plane table, indexed by plane and then by component.
  logic signed [31:0] plane_words [sfc_pkg::NumPlanesDef][sfc_pkg::WordsPerPlane];
  int unsigned       error_count;
  int unsigned       items_queued;
  int unsigned       quiet_cycles;

  sphere_frustum_cull_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A sphere is culled as soon as one plane puts its whole volume on the outside. The
  // test asks whether nx*cx + ny*cy + nz*cz + d + r is negative. The sum is formed at
  // Q32.32 scale in a wide accumulator, so nothing can overflow. A sphere that only
  // touches a plane, where the distance equals minus the radius, stays visible.
  function automatic logic sphere_in_frustum(sfc_pkg::req_t rq);
    logic signed [127:0] reach;
    for (int p = 0; p < sfc_pkg::NumPlanesDef; p++) begin
      reach = '0;
      reach += longint'($signed(plane_words[p][sfc_pkg::COMP_NX])) *
               longint'($signed(rq.center_x));
      reach += longint'($signed(plane_words[p][sfc_pkg::COMP_NY])) *
               longint'($signed(rq.center_y));
      reach += longint'($signed(plane_words[p][sfc_pkg::COMP_NZ])) *
               longint'($signed(rq.center_z));
      reach += longint'($signed(plane_words[p][sfc_pkg::COMP_D])) * 64'sd65536;
      reach += longint'(rq.sphere_radius) * 64'sd65536;
      if (reach[127]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Loads to plane indexes beyond the table are dropped by the block, so they are dropped
  // here too. A load gives no result.
  task automatic track_request(sfc_pkg::req_t rq);
    sfc_pkg::res_t res;
    if (rq.func == sfc_pkg::FUNC_LOAD) begin
      if (rq.plane_index < sfc_pkg::NumPlanesDef) begin
        plane_words[rq.plane_index][rq.component] = rq.coeff;
      end
    end else begin
      res.visible  = sphere_in_frustum(rq);
      res.last_out = rq.last_in;
      expected_results = {expected_results, res};
    end
  endtask

  // Each request gets the sender gap percentage of the phase it falls in. Loads to planes
  // that do not exist are not counted, since the block ignores them.
  task automatic queue_request(sfc_pkg::req_t rq);
    pending_req_t entry;
    int unsigned  phase;
    phase = items_queued * NumPhases / TargetItems;
    if (phase >= NumPhases) begin
      phase = NumPhases - 1;
    end
    entry.req     = rq;
    entry.gap_pct = GapPct[phase];
    pending_reqs  = {pending_reqs, entry};
    if (rq.func == sfc_pkg::FUNC_TEST || rq.plane_index < sfc_pkg::NumPlanesDef) begin
      items_queued++;
    end
  endtask

  // The fields that a load does not use carry random values, so that the block is seen to
  // ignore them.
  task automatic queue_load(int unsigned plane, sfc_pkg::comp_e comp,
                            logic signed [31:0] value);
    sfc_pkg::req_t rq;
    rq.func          = sfc_pkg::FUNC_LOAD;
    rq.plane_index   = plane[2:0];
    rq.component     = comp;
    rq.coeff         = value;
    rq.center_x      = $urandom;
    rq.center_y      = $urandom;
    rq.center_z      = $urandom;
    rq.sphere_radius = 31'($urandom);
    rq.last_in       = 1'($urandom_range(1));
    queue_request(rq);
  endtask

  task automatic queue_test(logic signed [31:0] cx, logic signed [31:0] cy,
                            logic signed [31:0] cz, logic [30:0] rad, logic last);
    sfc_pkg::req_t rq;
    rq.func          = sfc_pkg::FUNC_TEST;
    rq.plane_index   = 3'($urandom);
    rq.component     = sfc_pkg::comp_e'($urandom_range(3));
    rq.coeff         = $urandom;
    rq.center_x      = cx;
    rq.center_y      = cy;
    rq.center_z      = cz;
    rq.sphere_radius = rad;
    rq.last_in       = last;
    queue_request(rq);
  endtask

  // Most values lie in a range where geometry is meaningful. One in eight is a full-width
  // word, so that every bit of every field is exercised.
  function automatic logic signed [31:0] pick_word(int signed lo, int signed hi);
    if ($urandom_range(7) == 0) begin
      return $urandom;
    end
    return $urandom_range(hi - lo) + lo;
  endfunction

  // Driver: it takes note of a request at the edge that accepts it, then presents the next
  // one or stays idle. The start line is driven once per edge. The predictor's copy of the
  // plane table is cleared with the block's.
  always @(posedge clk_i) begin
    pending_req_t next_req;
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i   <= '0;
      foreach (plane_words[p, c]) begin
        plane_words[p][c] = '0;
      end
    end else if (!(start_i && busy_o)) begin
      if (start_i) begin
        track_request(req_i);
      end
      if (pending_reqs.size() != 0 && $urandom_range(99) >= pending_reqs[0].gap_pct) begin
        next_req = pending_reqs.pop_front();
        req_i   <= next_req.req;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must meet an expectation, and the fields are checked one by one.
  always @(posedge clk_i) begin
    sfc_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got visible=%0b last_out=%0b",
                 $time, res_o.visible, res_o.last_out);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_o.visible !== want.visible) begin
          $display("%0t: visible mismatch, expected %0b, got %0b", $time,
                   want.visible, res_o.visible);
          error_count++;
        end
        if (res_o.last_out !== want.last_out) begin
          $display("%0t: last_out mismatch, expected %0b, got %0b", $time,
                   want.last_out, res_o.last_out);
          error_count++;
        end
      end
    end
  end

  // Watchdog: it counts the edges at which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    int unsigned        batch;
    int unsigned        kind;
    sfc_pkg::req_t      rq;

    rst_ni       = 1'b0;
    items_queued = 0;

    // With the table just cleared, every sphere is visible, the extreme ones too.
    queue_test(MinWord, MaxWord, 32'sd0, 31'd0, 1'b1);
    queue_test(MaxWord, MinWord, MinWord, MaxRad, 1'b0);
    // Left plane x >= 0: a point at x = -1 is culled. A sphere of radius 1 only touches the
    // plane and stays visible. A sphere one step smaller is culled.
    queue_load(0, sfc_pkg::COMP_NX, One);
    queue_test(-One, 32'sd0, 32'sd0, 31'd0, 1'b0);
    queue_test(-One, 32'sd0, 32'sd0, 31'(One), 1'b1);
    queue_test(-One, 32'sd0, 32'sd0, 31'(One - 1), 1'b0);
    // Moving the plane by its offset moves the boundary that the sphere touches.
    queue_load(0, sfc_pkg::COMP_D, One);
    queue_test(-2 * One, 32'sd0, 32'sd0, 31'(One), 1'b1);
    // Loads to plane indexes beyond the table must be ignored.
    queue_load(6, sfc_pkg::COMP_NX, -One);
    queue_load(7, sfc_pkg::COMP_D, MinWord);
    queue_test(-2 * One - 1, 32'sd0, 32'sd0, 31'(One), 1'b0);
    // The extreme words push the exact sum close to its largest magnitude.
    queue_load(5, sfc_pkg::COMP_NY, MinWord);
    queue_load(5, sfc_pkg::COMP_NZ, MaxWord);
    queue_test(32'sd0, MaxWord, MaxWord, MaxRad, 1'b1);
    queue_test(32'sd0, MinWord, MinWord, MaxRad, 1'b0);
    queue_test(MinWord, MinWord, MinWord, 31'd0, 1'b1);
    queue_load(5, sfc_pkg::COMP_D, MaxWord);
    queue_test(32'sd0, MinWord, MinWord, 31'd0, 1'b1);

    // Random part. Most sequences load a whole or part frustum and then test a batch of
    // spheres, the last of which carries the batch mark. The rest is random noise.
    while (items_queued < TargetItems) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        for (int p = 0; p < sfc_pkg::NumPlanesDef; p++) begin
          for (int c = 0; c < sfc_pkg::WordsPerPlane; c++) begin
            if (kind < 50 || $urandom_range(5) == 0) begin
              if (c == sfc_pkg::COMP_D) begin
                queue_load(p, sfc_pkg::comp_e'(c), pick_word(-20 * One, 150 * One));
              end else begin
                queue_load(p, sfc_pkg::comp_e'(c), pick_word(-One, One));
              end
            end
          end
        end
        if ($urandom_range(3) == 0) begin
          queue_load($urandom_range(7, 6), sfc_pkg::comp_e'($urandom_range(3)), $urandom);
        end
        batch = $urandom_range(12, 3);
        for (int i = 0; i < batch; i++) begin
          cx = pick_word(-100 * One, 100 * One);
          cy = pick_word(-100 * One, 100 * One);
          cz = pick_word(-100 * One, 100 * One);
          queue_test(cx, cy, cz, 31'(pick_word(0, 50 * One)), i == batch - 1);
        end
      end else begin
        batch = $urandom_range(10, 1);
        for (int i = 0; i < batch; i++) begin
          rq.func          = sfc_pkg::func_e'($urandom_range(1));
          rq.plane_index   = 3'($urandom);
          rq.component     = sfc_pkg::comp_e'($urandom_range(3));
          rq.coeff         = $urandom;
          rq.center_x      = $urandom;
          rq.center_y      = $urandom;
          rq.center_z      = $urandom;
          rq.sphere_radius = 31'($urandom);
          rq.last_in       = 1'($urandom_range(1));
          queue_request(rq);
        end
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request has been taken and every result has come back.
    while (pending_reqs.size() != 0 || start_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/sfc_pkg.sv
sv/sfc_plane_table.sv
sv/sfc_plane_lane.sv
sv/sphere_frustum_cull_top.sv
tb/sphere_frustum_cull_top_tb.sv
